>>> rtl/ssv_pkg.sv
`default_nettype none

package ssv_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned NOTE_W      = 7;
   localparam int unsigned LEVEL_W     = 8;
   localparam int unsigned STEP_W      = 3;
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned TONE_W      = 12;

   localparam logic [15:0] SPS_RESET       = 16'd5143;
   localparam logic [31:0] STEP_WORD_RESET = 32'hFFBC_FFBC;

   localparam logic [11:0] TENTH_Q15 = 12'd3277;

   // odd sine polynomial, Q30
   localparam logic [31:0] SC1 = 32'd1686629713;
   localparam logic [31:0] SC3 = 32'd693598668;
   localparam logic [31:0] SC5 = 32'd85569306;
   localparam logic [31:0] SC7 = 32'd5026995;
   localparam logic [31:0] SC9 = 32'd172272;

   // floor(2^24 / 255)
   localparam logic [16:0] RECIP_255 = 17'd65793;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SAMPLES_PER_STEP = 3'd0,
      REG_STEPS_01         = 3'd1,
      REG_STEPS_23         = 3'd2,
      REG_STEPS_45         = 3'd3,
      REG_STEPS_67         = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        phase;
      logic [LEVEL_W-1:0] level;
      logic [STEP_W-1:0]  step;
   } seq_item_type;

   typedef struct packed {
      logic               neg;
      logic [TONE_W-1:0]  mag;
      logic [LEVEL_W-1:0] level;
      logic [STEP_W-1:0]  step;
   } tone_item_type;

   // top octave (notes 120..131), Hz in Q16.16
   function automatic logic [31:0] note_top(input logic [3:0] semi);
      logic [31:0] f;
      case (semi)
         4'd0:    f = 32'd548668578;
         4'd1:    f = 32'd581294109;
         4'd2:    f = 32'd615859655;
         4'd3:    f = 32'd652480576;
         4'd4:    f = 32'd691279090;
         4'd5:    f = 32'd732384689;
         4'd6:    f = 32'd775934544;
         4'd7:    f = 32'd822074013;
         4'd8:    f = 32'd870957070;
         4'd9:    f = 32'd922746880;
         4'd10:   f = 32'd977616271;
         4'd11:   f = 32'd1035748353;
         default: f = 32'd0;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ssv_req_if.sv
`default_nettype none

interface ssv_req_if;
   logic valid;
   logic ready;
   logic playing;

   modport source (output valid, output playing, input ready);
   modport sink (input valid, input playing, output ready);
endinterface

`default_nettype wire

>>> rtl/ssv_rsp_if.sv
`default_nettype none

interface ssv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ssv_pkg::SAMPLE_W-1:0] sample_out;
   logic [ssv_pkg::STEP_W-1:0]          step_now;

   modport source (output valid, output sample_out, output step_now, input ready);
   modport sink (input valid, input sample_out, input step_now, output ready);
endinterface

`default_nettype wire

>>> rtl/ssv_sequencer.sv
`default_nettype none

module ssv_sequencer #(
   parameter int STEPS       = 8,
   parameter int SAMPLE_RATE = 48000
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [ssv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ssv_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire logic                               in_playing,
   output logic                                    out_valid,
   input  wire logic                               out_ready,
   output ssv_pkg::seq_item_type                   out_item
);

   localparam int IDX_W   = $clog2(STEPS);
   localparam int NOTES   = 1 << ssv_pkg::NOTE_W;

   logic [15:0]       sps_ff;
   logic [31:0]       steps_ff [4];
   logic [31:0]       phase_acc_ff, phase_acc_in;
   logic [31:0]       phase_step_ff, phase_step_in;
   logic [7:0]        level_ff, level_in;
   logic [IDX_W-1:0]  step_index_ff, step_index_in;
   logic [15:0]       tick_count_ff, tick_count_in;
   logic              v_ff;
   ssv_pkg::seq_item_type item_ff;

   logic [31:0]       inc_table [NOTES];
   logic [IDX_W+2:0]  cur_ext, next_ext;
   logic [2:0]        word_sel;
   logic [31:0]       pair;
   logic [15:0]       word;
   logic              boundary;
   logic [16:0]       tick_inc;
   logic              accept;

   // increment per MIDI note, fixed at elaboration
   for (genvar n = 0; n < NOTES; n++) begin : g_inc
      localparam int unsigned OCT  = n / 12;
      localparam int unsigned SEMI = n % 12;
      localparam logic [63:0] FREQ =
         64'(ssv_pkg::note_top(4'(SEMI)) >> (10 - OCT));
      localparam logic [63:0] INC = (FREQ << 16) / SAMPLE_RATE;
      assign inc_table[n] = INC[31:0];
   end

   assign in_ready = !v_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      cur_ext  = (IDX_W+3)'(step_index_ff);
      word_sel = cur_ext[2:0];
      pair     = steps_ff[word_sel[2:1]];
      word     = word_sel[0] ? pair[31:16] : pair[15:0];
      boundary = in_playing && (tick_count_ff == '0);

      phase_step_in = phase_step_ff;
      level_in      = level_ff;
      step_index_in = step_index_ff;
      if (boundary) begin
         if (word[15]) begin
            phase_step_in = inc_table[word[6:0]];
            level_in      = word[14:7];
         end else begin
            level_in = '0;
         end
         if (step_index_ff == IDX_W'(STEPS - 1)) begin
            step_index_in = '0;
         end else begin
            step_index_in = step_index_ff + 1'b1;
         end
      end

      tick_inc      = 17'(tick_count_ff) + 17'd1;
      tick_count_in = tick_count_ff;
      if (in_playing) begin
         tick_count_in = (tick_inc >= {1'b0, sps_ff}) ? '0 : tick_inc[15:0];
      end

      phase_acc_in = phase_acc_ff + phase_step_in;
      next_ext     = (IDX_W+3)'(step_index_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sps_ff <= ssv_pkg::SPS_RESET;
         for (int i = 0; i < 4; i++) begin
            steps_ff[i] <= ssv_pkg::STEP_WORD_RESET;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            ssv_pkg::REG_SAMPLES_PER_STEP: sps_ff      <= csr_wdata[15:0];
            ssv_pkg::REG_STEPS_01:         steps_ff[0] <= csr_wdata;
            ssv_pkg::REG_STEPS_23:         steps_ff[1] <= csr_wdata;
            ssv_pkg::REG_STEPS_45:         steps_ff[2] <= csr_wdata;
            ssv_pkg::REG_STEPS_67:         steps_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff  <= '0;
         phase_step_ff <= '0;
         level_ff      <= '0;
         step_index_ff <= '0;
         tick_count_ff <= '0;
      end else if (accept) begin
         phase_acc_ff  <= phase_acc_in;
         phase_step_ff <= phase_step_in;
         level_ff      <= level_in;
         step_index_ff <= step_index_in;
         tick_count_ff <= tick_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   // sine uses the phase from before this tick's advance
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.phase <= phase_acc_ff;
         item_ff.level <= level_in;
         item_ff.step  <= next_ext[2:0];
      end
   end

   assign out_valid = v_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

>>> rtl/ssv_sine.sv
`default_nettype none

module ssv_sine #(
   parameter int DEPTH = 1024
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire ssv_pkg::seq_item_type in_item,
   output logic                out_valid,
   input  wire logic           out_ready,
   output ssv_pkg::tone_item_type out_item
);

   localparam int NSTG    = 10;
   localparam int DEPTH_W = $clog2(DEPTH);
   localparam int NUM_W   = 18 + DEPTH_W;
   localparam int RECIP_W = 33 - DEPTH_W;
   localparam int PROD_W  = NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / DEPTH);

   logic [NSTG-1:0] v_ff;
   logic [NSTG:0]   en;

   logic [ssv_pkg::LEVEL_W-1:0] level_ff [NSTG];
   logic [ssv_pkg::STEP_W-1:0]  step_ff  [NSTG];

   logic [DEPTH_W-1:0] idx_ff [2];
   logic [17:0]        qe_ff;
   logic [30:0]        x_ff  [2:7];
   logic [30:0]        x2_ff [3:6];
   logic [1:0]         quad_ff [2:8];
   logic [31:0]        h_ff  [4:7];
   logic [31:0]        s_ff;
   logic [ssv_pkg::TONE_W-1:0] t1_ff;
   logic               neg_ff;

   logic [32+DEPTH_W:0]  idx_prod;
   logic [NUM_W-1:0]     num0, num1, qd, rem;
   logic [PROD_W-1:0]    q_prod;
   logic [17:0]          t_val;
   logic [16:0]          f0, f_val;
   logic [61:0]          x2_prod;
   logic [62:0]          h4_prod, h5_prod, h6_prod, h7_prod, s_prod;
   logic [32:0]          q_round;
   logic [14:0]          q_cap;
   logic [27:0]          t1_prod;

   always_comb begin
      en[NSTG] = out_ready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         level_ff[0] <= in_item.level;
         step_ff[0]  <= in_item.step;
      end
      for (int i = 1; i < NSTG; i++) begin
         if (en[i]) begin
            level_ff[i] <= level_ff[i-1];
            step_ff[i]  <= step_ff[i-1];
         end
      end
   end

   always_comb begin
      // table index, then t = idx * 2^18 / DEPTH by reciprocal and one fixup
      idx_prod = (33+DEPTH_W)'(in_item.phase) * (33+DEPTH_W)'(DEPTH);
      num0     = {idx_ff[0], 18'd0};
      q_prod   = PROD_W'(num0) * PROD_W'(RECIP);
      num1     = {idx_ff[1], 18'd0};
      qd       = NUM_W'(32'(qe_ff) * 32'(DEPTH));
      rem      = num1 - qd;
      t_val    = (rem >= NUM_W'(DEPTH)) ? 18'(qe_ff + 18'd1) : qe_ff;
      f0       = {1'b0, t_val[15:0]};
      f_val    = t_val[16] ? 17'h10000 - f0 : f0;

      x2_prod  = 62'(x_ff[3 - 1]) * 62'(x_ff[3 - 1]);
      h4_prod  = 63'(x2_ff[3]) * 63'(ssv_pkg::SC9);
      h5_prod  = 63'(x2_ff[4]) * 63'(h_ff[4]);
      h6_prod  = 63'(x2_ff[5]) * 63'(h_ff[5]);
      h7_prod  = 63'(x2_ff[6]) * 63'(h_ff[6]);
      s_prod   = 63'(x_ff[7]) * 63'(h_ff[7]);

      q_round  = 33'(s_ff) + 33'd16384;
      q_cap    = (q_round[32:15] > 18'd32767) ? 15'h7FFF : q_round[29:15];
      t1_prod  = 28'(q_cap) * 28'(ssv_pkg::TENTH_Q15) + 28'd16384;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         idx_ff[0] <= idx_prod[32 +: DEPTH_W];
      end
      if (en[1]) begin
         idx_ff[1] <= idx_ff[0];
         qe_ff     <= q_prod[49:32];
      end
      if (en[2]) begin
         x_ff[2]    <= {f_val, 14'd0};
         quad_ff[2] <= t_val[17:16];
      end
      if (en[3]) begin
         x_ff[3]    <= x_ff[2];
         x2_ff[3]   <= x2_prod[60:30];
         quad_ff[3] <= quad_ff[2];
      end
      if (en[4]) begin
         x_ff[4]    <= x_ff[3];
         x2_ff[4]   <= x2_ff[3];
         h_ff[4]    <= ssv_pkg::SC7 - h4_prod[61:30];
         quad_ff[4] <= quad_ff[3];
      end
      if (en[5]) begin
         x_ff[5]    <= x_ff[4];
         x2_ff[5]   <= x2_ff[4];
         h_ff[5]    <= ssv_pkg::SC5 - h5_prod[61:30];
         quad_ff[5] <= quad_ff[4];
      end
      if (en[6]) begin
         x_ff[6]    <= x_ff[5];
         x2_ff[6]   <= x2_ff[5];
         h_ff[6]    <= ssv_pkg::SC3 - h6_prod[61:30];
         quad_ff[6] <= quad_ff[5];
      end
      if (en[7]) begin
         x_ff[7]    <= x_ff[6];
         h_ff[7]    <= ssv_pkg::SC1 - h7_prod[61:30];
         quad_ff[7] <= quad_ff[6];
      end
      if (en[8]) begin
         s_ff       <= s_prod[61:30];
         quad_ff[8] <= quad_ff[7];
      end
      if (en[9]) begin
         t1_ff  <= t1_prod[15 +: ssv_pkg::TONE_W];
         neg_ff <= quad_ff[8][1];
      end
   end

   assign out_valid      = v_ff[NSTG-1];
   assign out_item.neg   = neg_ff;
   assign out_item.mag   = t1_ff;
   assign out_item.level = level_ff[NSTG-1];
   assign out_item.step  = step_ff[NSTG-1];

endmodule

`default_nettype wire

>>> rtl/ssv_scale.sv
`default_nettype none

module ssv_scale (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire ssv_pkg::tone_item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic signed [ssv_pkg::SAMPLE_W-1:0] out_sample,
   output logic [ssv_pkg::STEP_W-1:0]          out_step
);

   localparam int NSTG = 3;

   logic [NSTG-1:0] v_ff;
   logic [NSTG:0]   en;

   logic [19:0]                 p_ff [2];
   logic [ssv_pkg::TONE_W-1:0]  q0_ff;
   logic                        neg_ff  [2];
   logic [ssv_pkg::STEP_W-1:0]  step_ff [NSTG];
   logic [ssv_pkg::SAMPLE_W-1:0] sample_ff;

   logic [19:0]                 p_val;
   logic [36:0]                 q_prod;
   logic [19:0]                 rem;
   logic [ssv_pkg::TONE_W-1:0]  t2;
   logic [ssv_pkg::SAMPLE_W-1:0] t2_ext;

   always_comb begin
      en[NSTG] = out_ready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // divide by 255: reciprocal estimate, low by at most one
   always_comb begin
      p_val  = 20'(in_item.mag) * 20'(in_item.level) + 20'd127;
      q_prod = 37'(p_ff[0]) * 37'(ssv_pkg::RECIP_255);
      rem    = p_ff[1] - 20'(q0_ff) * 20'd255;
      t2     = (rem >= 20'd255) ? q0_ff + 1'b1 : q0_ff;
      t2_ext = ssv_pkg::SAMPLE_W'(t2);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_ff[0]    <= p_val;
         neg_ff[0]  <= in_item.neg;
         step_ff[0] <= in_item.step;
      end
      if (en[1]) begin
         p_ff[1]    <= p_ff[0];
         q0_ff      <= q_prod[24 +: ssv_pkg::TONE_W];
         neg_ff[1]  <= neg_ff[0];
         step_ff[1] <= step_ff[0];
      end
      if (en[2]) begin
         sample_ff  <= neg_ff[1] ? 16'd0 - t2_ext : t2_ext;
         step_ff[2] <= step_ff[1];
      end
   end

   assign out_valid  = v_ff[NSTG-1];
   assign out_sample = sample_ff;
   assign out_step   = step_ff[NSTG-1];

endmodule

`default_nettype wire

>>> rtl/step_sequencer_sine_voice_top.sv
// An input reaches the output register through the sequencer, sine and gain stages.
// Throughput: one item per cycle unless stalled; the bound is the sequencer state
// register, updated once per accepted tick, and the 13-stage sine and gain pipeline.
// Every stage has its own ready, so bubbles close up while the output is stalled.
// Reset (synchronous, active high) clears the pipeline valids and the sequencer
// state and loads the configuration registers with their default values.
`default_nettype none

module step_sequencer_sine_voice_top #(
   parameter int STEPS            = 8,
   parameter int SAMPLE_RATE      = 48000,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [ssv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ssv_pkg::CSR_DATA_W-1:0]  csr_wdata,
   ssv_req_if.sink                              req_ch,
   ssv_rsp_if.source                            rsp_ch
);

   logic                   seq_valid, seq_ready;
   ssv_pkg::seq_item_type  seq_item;
   logic                   tone_valid, tone_ready;
   ssv_pkg::tone_item_type tone_item;

   ssv_sequencer #(
      .STEPS       (STEPS),
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_playing (req_ch.playing),
      .out_valid  (seq_valid),
      .out_ready  (seq_ready),
      .out_item   (seq_item)
   );

   ssv_sine #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seq_valid),
      .in_ready  (seq_ready),
      .in_item   (seq_item),
      .out_valid (tone_valid),
      .out_ready (tone_ready),
      .out_item  (tone_item)
   );

   ssv_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (tone_valid),
      .in_ready   (tone_ready),
      .in_item    (tone_item),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_sample (rsp_ch.sample_out),
      .out_step   (rsp_ch.step_now)
   );

endmodule

`default_nettype wire

>>> rtl/ssv_checker.sv
`default_nettype none

module ssv_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [ssv_pkg::SAMPLE_W-1:0] sample_out,
   input wire logic [ssv_pkg::STEP_W-1:0]          step_now
);

   localparam logic [4:0] CAPACITY = 5'd14;

   logic [4:0] pending_ff;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 5'(req_xfer) - 5'(rsp_xfer);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(sample_out) && $stable(step_now))
      else $error("result changed while stalled");

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (sample_out <= 16'sd3277) && (sample_out >= -16'sd3277))
      else $error("sample exceeds the 0.1 full-scale bound");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 5'd0)
      else $error("result without an outstanding input transfer");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CAPACITY)
      else $error("more items in flight than pipeline stages");

endmodule

bind step_sequencer_sine_voice_top ssv_checker u_ssv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .sample_out (rsp_ch.sample_out),
   .step_now   (rsp_ch.step_now)
);

`default_nettype wire
